// ===== rtl/core/rbs_pkg.sv =====
// ----------------------------------------------------------------------------
// rbs_pkg - shared definitions for the relay/backup selector
// Widths, result codes, microcode word layout and the microcode program.
// ----------------------------------------------------------------------------
package rbs_pkg;

  localparam int AddrW    = 16;
  localparam int ValW     = 16;
  localparam int SqW      = 32;   // square of a 16-bit value
  localparam int DsqW     = 33;   // squared own-to-candidate distance
  localparam int NW       = 35;   // signed angle numerator S + B*B - D*D
  localparam int WW       = 48;   // energy times squared distance
  localparam int MulBW    = ValW + 1;
  localparam int PW       = NW + MulBW;
  localparam int AccW     = 84;
  localparam int PcW      = 5;
  localparam int InDataW  = 80;
  localparam int OutDataW = 56;
  localparam int CfgIdxW  = 2;

  // result codes
  localparam logic [1:0] OUT_BASE   = 2'd0;
  localparam logic [1:0] OUT_RELAY  = 2'd1;
  localparam logic [1:0] OUT_BACKUP = 2'd2;
  localparam logic [1:0] OUT_IGNORE = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_OWN_X     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_OWN_Y     = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_OWN_DBASE = 2'd2;

  // multiplier A operand (signed, NW bits)
  localparam logic [3:0] MA_ZERO = 4'd0;
  localparam logic [3:0] MA_DX   = 4'd1;
  localparam logic [3:0] MA_DY   = 4'd2;
  localparam logic [3:0] MA_OB   = 4'd3;
  localparam logic [3:0] MA_CD   = 4'd4;
  localparam logic [3:0] MA_ID   = 4'd5;
  localparam logic [3:0] MA_DC2  = 4'd6;
  localparam logic [3:0] MA_DI2  = 4'd7;
  localparam logic [3:0] MA_NC   = 4'd8;
  localparam logic [3:0] MA_NI   = 4'd9;

  // multiplier B operand (unsigned 16 bits)
  localparam logic [3:0] MB_ZERO = 4'd0;
  localparam logic [3:0] MB_DX   = 4'd1;
  localparam logic [3:0] MB_DY   = 4'd2;
  localparam logic [3:0] MB_OB   = 4'd3;
  localparam logic [3:0] MB_CD   = 4'd4;
  localparam logic [3:0] MB_ID   = 4'd5;
  localparam logic [3:0] MB_CE   = 4'd6;
  localparam logic [3:0] MB_IE   = 4'd7;
  localparam logic [3:0] MB_WC0  = 4'd8;
  localparam logic [3:0] MB_WC1  = 4'd9;
  localparam logic [3:0] MB_WC2  = 4'd10;
  localparam logic [3:0] MB_WI0  = 4'd11;
  localparam logic [3:0] MB_WI1  = 4'd12;
  localparam logic [3:0] MB_WI2  = 4'd13;

  // accumulator
  localparam logic [1:0] ACC_NOP  = 2'd0;
  localparam logic [1:0] ACC_LOAD = 2'd1;
  localparam logic [1:0] ACC_ADD  = 2'd2;
  localparam logic [1:0] ACC_SUB  = 2'd3;

  localparam logic [1:0] SRC_P   = 2'd0;
  localparam logic [1:0] SRC_SI  = 2'd1;
  localparam logic [1:0] SRC_B2  = 2'd2;
  localparam logic [1:0] SRC_DI2 = 2'd3;

  localparam logic [1:0] SH_0  = 2'd0;
  localparam logic [1:0] SH_16 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  // jump conditions
  localparam logic [2:0] C_NONE     = 3'd0;
  localparam logic [2:0] C_ALWAYS   = 3'd1;
  localparam logic [2:0] C_BASEFLAG = 3'd2;
  localparam logic [2:0] C_KNOWN    = 3'd3;
  localparam logic [2:0] C_EMPTY    = 3'd4;
  localparam logic [2:0] C_WIN      = 3'd5;
  localparam logic [2:0] C_SLOT0    = 3'd6;

  // state operations
  localparam logic [2:0] OP_NONE      = 3'd0;
  localparam logic [2:0] OP_SET_BASE  = 3'd1;
  localparam logic [2:0] OP_SET_IGN   = 3'd2;
  localparam logic [2:0] OP_TAKE      = 3'd3;
  localparam logic [2:0] OP_NEXT_SLOT = 3'd4;
  localparam logic [2:0] OP_FIN       = 3'd5;

  // program labels
  localparam logic [PcW-1:0] PC_SLOT = 5'd7;
  localparam logic [PcW-1:0] PC_IGN  = 5'd21;
  localparam logic [PcW-1:0] PC_NEXT = 5'd22;
  localparam logic [PcW-1:0] PC_TAKE = 5'd23;
  localparam logic [PcW-1:0] PC_BASE = 5'd24;
  localparam logic [PcW-1:0] PC_FIN  = 5'd25;

  typedef struct packed {
    logic [3:0] ma;
    logic [3:0] mb;
    logic [1:0] acc_op;
    logic [1:0] acc_src;
    logic [1:0] acc_sh;
    logic       wr_s;
    logic       wr_b2;
    logic       wr_dc2;
    logic       wr_di2;
    logic       wr_wc;
    logic       wr_wi;
    logic       wr_nc;
    logic       wr_ni;
  } dp_ctrl_t;

  typedef struct packed {
    dp_ctrl_t       dp;
    logic [2:0]     op;
    logic [2:0]     cond;
    logic [PcW-1:0] target;
  } uword_t;

  typedef struct packed {
    logic base_flag;
    logic base_known;
    logic slot_empty;
    logic win;
    logic slot_sel;
  } dp_status_t;

  // Microcode. Products are registered: a step reads the product that the step before it issued.
  function automatic uword_t ucode(input logic [PcW-1:0] pc);
    uword_t w;
    w = '0;
    unique case (pc)
      5'd0: begin w.cond = C_BASEFLAG; w.target = PC_BASE; end
      5'd1: begin
        w.cond = C_KNOWN; w.target = PC_IGN;
        w.dp.ma = MA_DX; w.dp.mb = MB_DX;
      end
      5'd2: begin
        w.dp.ma = MA_DY; w.dp.mb = MB_DY;
        w.dp.acc_op = ACC_LOAD; w.dp.acc_src = SRC_P;
      end
      5'd3: begin
        w.dp.ma = MA_OB; w.dp.mb = MB_OB;
        w.dp.acc_op = ACC_ADD; w.dp.acc_src = SRC_P;
      end
      5'd4: begin
        w.dp.ma = MA_CD; w.dp.mb = MB_CD;
        w.dp.wr_s = 1'b1; w.dp.wr_b2 = 1'b1;
        w.dp.acc_op = ACC_ADD; w.dp.acc_src = SRC_P;
      end
      5'd5: begin
        w.dp.wr_dc2 = 1'b1;
        w.dp.acc_op = ACC_SUB; w.dp.acc_src = SRC_P;
      end
      5'd6: begin w.dp.wr_nc = 1'b1; end
      // slot compare loop
      5'd7: begin
        w.cond = C_EMPTY; w.target = PC_TAKE;
        w.dp.ma = MA_ID; w.dp.mb = MB_ID;
      end
      5'd8: begin
        w.dp.wr_di2 = 1'b1;
        w.dp.acc_op = ACC_LOAD; w.dp.acc_src = SRC_SI;
      end
      5'd9: begin
        w.dp.ma = MA_DI2; w.dp.mb = MB_CE;
        w.dp.acc_op = ACC_ADD; w.dp.acc_src = SRC_B2;
      end
      5'd10: begin
        w.dp.ma = MA_DC2; w.dp.mb = MB_IE;
        w.dp.acc_op = ACC_SUB; w.dp.acc_src = SRC_DI2;
        w.dp.wr_wc = 1'b1;
      end
      5'd11: begin w.dp.wr_wi = 1'b1; w.dp.wr_ni = 1'b1; end
      5'd12: begin w.dp.ma = MA_NC; w.dp.mb = MB_WC0; end
      5'd13: begin
        w.dp.ma = MA_NC; w.dp.mb = MB_WC1;
        w.dp.acc_op = ACC_LOAD; w.dp.acc_src = SRC_P; w.dp.acc_sh = SH_0;
      end
      5'd14: begin
        w.dp.ma = MA_NC; w.dp.mb = MB_WC2;
        w.dp.acc_op = ACC_ADD; w.dp.acc_src = SRC_P; w.dp.acc_sh = SH_16;
      end
      5'd15: begin
        w.dp.ma = MA_NI; w.dp.mb = MB_WI0;
        w.dp.acc_op = ACC_ADD; w.dp.acc_src = SRC_P; w.dp.acc_sh = SH_32;
      end
      5'd16: begin
        w.dp.ma = MA_NI; w.dp.mb = MB_WI1;
        w.dp.acc_op = ACC_SUB; w.dp.acc_src = SRC_P; w.dp.acc_sh = SH_0;
      end
      5'd17: begin
        w.dp.ma = MA_NI; w.dp.mb = MB_WI2;
        w.dp.acc_op = ACC_SUB; w.dp.acc_src = SRC_P; w.dp.acc_sh = SH_16;
      end
      5'd18: begin
        w.dp.acc_op = ACC_SUB; w.dp.acc_src = SRC_P; w.dp.acc_sh = SH_32;
      end
      5'd19: begin w.cond = C_WIN;   w.target = PC_TAKE; end
      5'd20: begin w.cond = C_SLOT0; w.target = PC_NEXT; end
      5'd21: begin w.op = OP_SET_IGN;   w.cond = C_ALWAYS; w.target = PC_FIN; end
      5'd22: begin w.op = OP_NEXT_SLOT; w.cond = C_ALWAYS; w.target = PC_SLOT; end
      5'd23: begin w.op = OP_TAKE;      w.cond = C_ALWAYS; w.target = PC_FIN; end
      5'd24: begin w.op = OP_SET_BASE; end
      5'd25: begin w.op = OP_FIN; end
      default: begin w.cond = C_ALWAYS; w.target = PC_FIN; end
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/core/relay_backup_selector.sv =====
// ----------------------------------------------------------------------------
// relay_backup_selector - relay and backup choice from neighbor reports
// Scores neighbor reports and keeps the best relay, a backup and the base.
// ----------------------------------------------------------------------------
// Usage:
//  - in_*: one neighbor report per transaction. tuser carries the base flag.
//  - out_*: one result per report: outcome and the relay, backup and base
//    addresses after that report.
//  - cfg_*: own x, own y and own distance to base; write only while idle.
// Each report takes one path through the microcode: a base report, a report
// while a base is already known, an empty relay slot, a full relay
// comparison, a candidate that takes the backup slot, and a candidate that
// loses to both relay and backup.
// The microcode drives one shared 35x17 multiplier that issues one product
// per step, and the score difference takes six partial products per slot.
// The next report can be taken as soon as the result is loaded.
// One report is in flight at a time; in_tready is low while it runs.
// The result sits in an output register, so a report can be accepted while
// the previous result waits. If that result is still not taken when the next
// one finishes, the sequencer holds on its last step until out_tready.
// Reset clears the slots, the base address and the configuration to zero.
// ----------------------------------------------------------------------------
module relay_backup_selector (
  input  logic                          clk,
  input  logic                          rst_n,
  // input reports
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // [15:0] source_addr, [31:16] energy, [47:32] pos_x, [63:48] pos_y,
  // [79:64] cand_dist_base
  input  logic [rbs_pkg::InDataW-1:0]   in_tdata,
  // [0] from_base
  input  logic                          in_tuser,
  // results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [1:0] outcome, [17:2] relay_out, [33:18] backup_out, [49:34] base_out,
  // [55:50] zero
  output logic [rbs_pkg::OutDataW-1:0]  out_tdata,
  // configuration
  input  logic                          cfg_we,
  input  logic [rbs_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [rbs_pkg::ValW-1:0]      cfg_wdata
);

  logic [rbs_pkg::ValW-1:0]     own_x_r, own_y_r, own_dbase_r;
  logic                         out_valid_r;
  logic [rbs_pkg::OutDataW-1:0] out_data_r;

  logic                         accept;
  logic                         busy, done, out_hold;
  rbs_pkg::dp_ctrl_t            dp_ctrl;
  logic [2:0]                   dp_op;
  rbs_pkg::dp_status_t          dp_status;
  logic [1:0]                   outcome;
  logic [rbs_pkg::AddrW-1:0]    relay_addr, backup_addr, base_addr;

  assign in_tready = !busy;
  assign accept    = in_tvalid && in_tready;
  // a finished result cannot land while the previous one is still unread
  assign out_hold  = out_valid_r && !out_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_x_r     <= '0;
      own_y_r     <= '0;
      own_dbase_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        rbs_pkg::CFG_OWN_X:     own_x_r     <= cfg_wdata;
        rbs_pkg::CFG_OWN_Y:     own_y_r     <= cfg_wdata;
        rbs_pkg::CFG_OWN_DBASE: own_dbase_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rbs_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept),
    .out_hold (out_hold),
    .status   (dp_status),
    .dp_ctrl  (dp_ctrl),
    .dp_op    (dp_op),
    .busy     (busy),
    .done     (done)
  );

  rbs_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .ld           (accept),
    .in_from_base (in_tuser),
    .in_src       (in_tdata[15:0]),
    .in_energy    (in_tdata[31:16]),
    .in_pos_x     (in_tdata[47:32]),
    .in_pos_y     (in_tdata[63:48]),
    .in_dbase     (in_tdata[79:64]),
    .own_x        (own_x_r),
    .own_y        (own_y_r),
    .own_dbase    (own_dbase_r),
    .ctrl         (dp_ctrl),
    .op           (dp_op),
    .status       (dp_status),
    .outcome      (outcome),
    .relay_addr   (relay_addr),
    .backup_addr  (backup_addr),
    .base_addr    (base_addr)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= {6'b0, base_addr, backup_addr, relay_addr, outcome};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== rtl/core/rbs_sequencer.sv =====
// ----------------------------------------------------------------------------
// rbs_sequencer - microcode step counter
// Fetches the control word for the current step and resolves jumps.
// ----------------------------------------------------------------------------
module rbs_sequencer (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 out_hold,
  input  rbs_pkg::dp_status_t  status,
  output rbs_pkg::dp_ctrl_t    dp_ctrl,
  output logic [2:0]           dp_op,
  output logic                 busy,
  output logic                 done
);

  logic [rbs_pkg::PcW-1:0] pc_r, pc_nxt;
  logic                    busy_r, busy_nxt;
  rbs_pkg::uword_t         uw;
  logic                    take;

  assign uw = rbs_pkg::ucode(pc_r);

  always_comb begin
    unique case (uw.cond)
      rbs_pkg::C_NONE:     take = 1'b0;
      rbs_pkg::C_ALWAYS:   take = 1'b1;
      rbs_pkg::C_BASEFLAG: take = status.base_flag;
      rbs_pkg::C_KNOWN:    take = status.base_known;
      rbs_pkg::C_EMPTY:    take = status.slot_empty;
      rbs_pkg::C_WIN:      take = status.win;
      rbs_pkg::C_SLOT0:    take = !status.slot_sel;
      default:             take = 1'b0;
    endcase
  end

  assign done    = busy_r && (uw.op == rbs_pkg::OP_FIN) && !out_hold;
  assign busy    = busy_r;
  assign dp_ctrl = busy_r ? uw.dp : '0;
  assign dp_op   = busy_r ? uw.op : rbs_pkg::OP_NONE;

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (start) begin
      pc_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (uw.op == rbs_pkg::OP_FIN) begin
        if (!out_hold) busy_nxt = 1'b0;
      end else if (take) begin
        pc_nxt = uw.target;
      end else begin
        pc_nxt = pc_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= '0;
      busy_r <= 1'b0;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

endmodule

// ===== rtl/core/rbs_datapath.sv =====
// ----------------------------------------------------------------------------
// rbs_datapath - shared multiplier, accumulator and selection state
// One signed multiply per step, an 84-bit accumulator and the slot registers.
// ----------------------------------------------------------------------------
module rbs_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       ld,
  input  logic                       in_from_base,
  input  logic [rbs_pkg::AddrW-1:0]  in_src,
  input  logic [rbs_pkg::ValW-1:0]   in_energy,
  input  logic [rbs_pkg::ValW-1:0]   in_pos_x,
  input  logic [rbs_pkg::ValW-1:0]   in_pos_y,
  input  logic [rbs_pkg::ValW-1:0]   in_dbase,
  input  logic [rbs_pkg::ValW-1:0]   own_x,
  input  logic [rbs_pkg::ValW-1:0]   own_y,
  input  logic [rbs_pkg::ValW-1:0]   own_dbase,
  input  rbs_pkg::dp_ctrl_t          ctrl,
  input  logic [2:0]                 op,
  output rbs_pkg::dp_status_t        status,
  output logic [1:0]                 outcome,
  output logic [rbs_pkg::AddrW-1:0]  relay_addr,
  output logic [rbs_pkg::AddrW-1:0]  backup_addr,
  output logic [rbs_pkg::AddrW-1:0]  base_addr
);

  localparam int NW   = rbs_pkg::NW;
  localparam int PW   = rbs_pkg::PW;
  localparam int AccW = rbs_pkg::AccW;
  localparam int VW   = rbs_pkg::ValW;

  // candidate
  logic              flag_r;
  logic [VW-1:0]     src_r, ce_r, cd_r, dx_r, dy_r;

  // slots
  logic [VW-1:0]              rel_addr_r, rel_e_r, rel_d_r;
  logic [rbs_pkg::DsqW-1:0]   rel_s_r;
  logic [VW-1:0]              bk_addr_r, bk_e_r, bk_d_r;
  logic [rbs_pkg::DsqW-1:0]   bk_s_r;
  logic [VW-1:0]              base_r;
  logic                       slot_r;
  logic [1:0]                 outcome_r;

  // scratch
  logic [rbs_pkg::DsqW-1:0]   s_r;
  logic [rbs_pkg::SqW-1:0]    b2_r, dc2_r, di2_r;
  logic [rbs_pkg::WW-1:0]     wc_r, wi_r;
  logic signed [NW-1:0]       nc_r, ni_r;
  logic signed [PW-1:0]       p_r;
  logic signed [AccW-1:0]     acc_r;

  logic [VW-1:0]              inc_addr, inc_e, inc_d;
  logic [rbs_pkg::DsqW-1:0]   inc_s;
  logic signed [NW-1:0]       mul_a;
  logic [VW-1:0]              mul_b_u;
  logic signed [rbs_pkg::MulBW-1:0] mul_b;
  logic signed [AccW-1:0]     src_v, opnd;

  assign inc_addr = slot_r ? bk_addr_r : rel_addr_r;
  assign inc_e    = slot_r ? bk_e_r    : rel_e_r;
  assign inc_d    = slot_r ? bk_d_r    : rel_d_r;
  assign inc_s    = slot_r ? bk_s_r    : rel_s_r;

  always_comb begin
    unique case (ctrl.ma)
      rbs_pkg::MA_DX:  mul_a = {{(NW-VW){1'b0}}, dx_r};
      rbs_pkg::MA_DY:  mul_a = {{(NW-VW){1'b0}}, dy_r};
      rbs_pkg::MA_OB:  mul_a = {{(NW-VW){1'b0}}, own_dbase};
      rbs_pkg::MA_CD:  mul_a = {{(NW-VW){1'b0}}, cd_r};
      rbs_pkg::MA_ID:  mul_a = {{(NW-VW){1'b0}}, inc_d};
      rbs_pkg::MA_DC2: mul_a = {{(NW-rbs_pkg::SqW){1'b0}}, dc2_r};
      rbs_pkg::MA_DI2: mul_a = {{(NW-rbs_pkg::SqW){1'b0}}, di2_r};
      rbs_pkg::MA_NC:  mul_a = nc_r;
      rbs_pkg::MA_NI:  mul_a = ni_r;
      default:         mul_a = '0;
    endcase
  end

  always_comb begin
    unique case (ctrl.mb)
      rbs_pkg::MB_DX:  mul_b_u = dx_r;
      rbs_pkg::MB_DY:  mul_b_u = dy_r;
      rbs_pkg::MB_OB:  mul_b_u = own_dbase;
      rbs_pkg::MB_CD:  mul_b_u = cd_r;
      rbs_pkg::MB_ID:  mul_b_u = inc_d;
      rbs_pkg::MB_CE:  mul_b_u = ce_r;
      rbs_pkg::MB_IE:  mul_b_u = inc_e;
      rbs_pkg::MB_WC0: mul_b_u = wc_r[15:0];
      rbs_pkg::MB_WC1: mul_b_u = wc_r[31:16];
      rbs_pkg::MB_WC2: mul_b_u = wc_r[47:32];
      rbs_pkg::MB_WI0: mul_b_u = wi_r[15:0];
      rbs_pkg::MB_WI1: mul_b_u = wi_r[31:16];
      rbs_pkg::MB_WI2: mul_b_u = wi_r[47:32];
      default:         mul_b_u = '0;
    endcase
  end

  assign mul_b = {1'b0, mul_b_u};

  // accumulator operand: product is signed, stored values unsigned
  always_comb begin
    unique case (ctrl.acc_src)
      rbs_pkg::SRC_P:   src_v = {{(AccW-PW){p_r[PW-1]}}, p_r};
      rbs_pkg::SRC_SI:  src_v = {{(AccW-rbs_pkg::DsqW){1'b0}}, inc_s};
      rbs_pkg::SRC_B2:  src_v = {{(AccW-rbs_pkg::SqW){1'b0}}, b2_r};
      rbs_pkg::SRC_DI2: src_v = {{(AccW-rbs_pkg::SqW){1'b0}}, di2_r};
      default:          src_v = '0;
    endcase
  end

  always_comb begin
    case (ctrl.acc_sh)
      rbs_pkg::SH_16: opnd = src_v <<< 16;
      rbs_pkg::SH_32: opnd = src_v <<< 32;
      default:        opnd = src_v;
    endcase
  end

  // arithmetic registers
  always_ff @(posedge clk) begin
    p_r <= mul_a * mul_b;
    case (ctrl.acc_op)
      rbs_pkg::ACC_LOAD: acc_r <= opnd;
      rbs_pkg::ACC_ADD:  acc_r <= acc_r + opnd;
      rbs_pkg::ACC_SUB:  acc_r <= acc_r - opnd;
      default:           acc_r <= acc_r;
    endcase
    if (ctrl.wr_s)   s_r   <= acc_r[rbs_pkg::DsqW-1:0];
    if (ctrl.wr_b2)  b2_r  <= p_r[rbs_pkg::SqW-1:0];
    if (ctrl.wr_dc2) dc2_r <= p_r[rbs_pkg::SqW-1:0];
    if (ctrl.wr_di2) di2_r <= p_r[rbs_pkg::SqW-1:0];
    if (ctrl.wr_wc)  wc_r  <= p_r[rbs_pkg::WW-1:0];
    if (ctrl.wr_wi)  wi_r  <= p_r[rbs_pkg::WW-1:0];
    if (ctrl.wr_nc)  nc_r  <= acc_r[NW-1:0];
    if (ctrl.wr_ni)  ni_r  <= acc_r[NW-1:0];
  end

  // candidate capture
  always_ff @(posedge clk) begin
    if (ld) begin
      flag_r <= in_from_base;
      src_r  <= in_src;
      ce_r   <= in_energy;
      cd_r   <= in_dbase;
      dx_r   <= (in_pos_x >= own_x) ? in_pos_x - own_x : own_x - in_pos_x;
      dy_r   <= (in_pos_y >= own_y) ? in_pos_y - own_y : own_y - in_pos_y;
    end
  end

  // selection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_addr_r <= '0; rel_e_r <= '0; rel_d_r <= '0; rel_s_r <= '0;
      bk_addr_r  <= '0; bk_e_r  <= '0; bk_d_r  <= '0; bk_s_r  <= '0;
      base_r     <= '0;
      slot_r     <= 1'b0;
      outcome_r  <= rbs_pkg::OUT_IGNORE;
    end else if (ld) begin
      slot_r <= 1'b0;
    end else begin
      case (op)
        rbs_pkg::OP_SET_BASE: begin
          base_r    <= src_r;
          outcome_r <= rbs_pkg::OUT_BASE;
        end
        rbs_pkg::OP_SET_IGN:   outcome_r <= rbs_pkg::OUT_IGNORE;
        rbs_pkg::OP_NEXT_SLOT: slot_r    <= 1'b1;
        rbs_pkg::OP_TAKE: begin
          if (slot_r) begin
            bk_addr_r <= src_r; bk_e_r <= ce_r; bk_d_r <= cd_r; bk_s_r <= s_r;
            outcome_r <= rbs_pkg::OUT_BACKUP;
          end else begin
            rel_addr_r <= src_r; rel_e_r <= ce_r; rel_d_r <= cd_r; rel_s_r <= s_r;
            outcome_r  <= rbs_pkg::OUT_RELAY;
          end
        end
        default: ;
      endcase
    end
  end

  assign status.base_flag  = flag_r;
  assign status.base_known = (base_r != '0);
  assign status.slot_empty = (inc_addr == '0);
  assign status.win        = !acc_r[AccW-1] && (acc_r != '0);
  assign status.slot_sel   = slot_r;

  assign outcome     = outcome_r;
  assign relay_addr  = rel_addr_r;
  assign backup_addr = bk_addr_r;
  assign base_addr   = base_r;

endmodule

// ===== rtl/core/rbs_checker.sv =====
// ----------------------------------------------------------------------------
// rbs_checker - port-level checks for the relay/backup selector
// Bound to the top level; watches only its ports.
// ----------------------------------------------------------------------------
module rbs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [rbs_pkg::OutDataW-1:0] out_tdata
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // one report at a time: in_tready stays low after a transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready ##1 !in_tready)
    else $error("report accepted while one is in flight");

  // finishing a report always presents its result
  a_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_tready) |-> out_tvalid)
    else $error("sequencer finished without a result");

  // relay or backup changes only while no base is known
  a_nobase: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[1:0] == rbs_pkg::OUT_RELAY ||
                   out_tdata[1:0] == rbs_pkg::OUT_BACKUP)
    |-> out_tdata[49:34] == '0)
    else $error("slot updated with a known base");

endmodule

bind relay_backup_selector rbs_checker u_rbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
